### rtl/tam_pkg.sv
// Package for the thrust allocation mixer: request/result types, limits,
// register codes and the allocation coefficient table.
// No dependencies.
`default_nettype none

package tam_pkg;

   localparam int DATA_W         = 16;
   localparam int LIMIT_W        = 15;
   localparam int NUM_AXES       = 6;
   localparam int NUM_PROPS      = 8;
   localparam int NUM_FORCE_AXES = 3;
   localparam int COEF_FRAC_BITS_DEF = 14;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int DATA_MAX       = 32767;
   localparam int DATA_MIN       = -32768;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

   // register indexes (word address = paddr[2])
   typedef enum logic {
      REG_FORCE_LIMIT  = 1'b0,
      REG_TORQUE_LIMIT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] force_x;
      logic signed [DATA_W-1:0] force_y;
      logic signed [DATA_W-1:0] force_z;
      logic signed [DATA_W-1:0] torque_x;
      logic signed [DATA_W-1:0] torque_y;
      logic signed [DATA_W-1:0] torque_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] thrust_0;
      logic signed [DATA_W-1:0] thrust_1;
      logic signed [DATA_W-1:0] thrust_2;
      logic signed [DATA_W-1:0] thrust_3;
      logic signed [DATA_W-1:0] thrust_4;
      logic signed [DATA_W-1:0] thrust_5;
      logic signed [DATA_W-1:0] thrust_6;
      logic signed [DATA_W-1:0] thrust_7;
   } rsp_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] force_limit;
      logic [LIMIT_W-1:0] torque_limit;
   } limits_type;

   // coefficient magnitudes in millionths
   localparam longint COEF_MICRO [NUM_AXES] = '{
      295753, 79246, 216506, 430689, 1607354, 1176664
   };

   // +/-(k+1): coefficient magnitude k with sign, row per propeller
   localparam int ALLOC_MAP [NUM_PROPS][NUM_AXES] = '{
      '{ -1,  2,  3,  4, -5,  6 },
      '{  2,  1, -3, -5, -4, -6 },
      '{ -2, -1, -3,  5,  4, -6 },
      '{  1, -2,  3, -4,  5,  6 },
      '{  1, -2,  3,  4, -5, -6 },
      '{ -2, -1, -3, -5, -4,  6 },
      '{  2,  1, -3,  5,  4,  6 },
      '{ -1,  2,  3, -4,  5, -6 }
   };

   // quantized magnitude, halves away from zero (elaboration only)
   function automatic longint quant_coef(int k, int frac);
      return (COEF_MICRO[k] * (longint'(1) << frac) + 64'sd500000) / 64'sd1000000;
   endfunction

   // signed coefficient for propeller p, axis a
   function automatic int signed_coef(int p, int a, int frac);
      int     e;
      longint mag;
      e   = ALLOC_MAP[p][a];
      mag = quant_coef((e < 0) ? (-e - 1) : (e - 1), frac);
      return (e < 0) ? -int'(mag) : int'(mag);
   endfunction

endpackage

`default_nettype wire

### rtl/thrust_allocation_mixer_top.sv
// Thrust allocation mixer: clamp, constant-matrix product and rounding.
// Depends on tam_pkg, tam_csr, tam_clamp_stage, tam_mult_stage, tam_sum_stage.
//
// Usage:
//   req_* carries one request: force and torque vectors, six signed Q8.8
//   values, taken when req_valid and req_ready are both high.
//   rsp_* carries eight signed Q8.8 propeller thrusts per request.
//   csr_* is an APB-style port: force_limit at 0x0, torque_limit at 0x4;
//   write limits only while no request is in flight.
// Pipeline: the clamp register loads at acceptance, then the product register,
//   then the result register, which drives rsp_valid.
// Throughput: one request per cycle while rsp_ready holds high; each of the three
//   registers advances whenever it is empty or the next one takes its content.
// Reset: all three stages empty, both limits at 32767 (only -32768 is clamped).
// Receiver stall: the result register holds, the pipeline fills up behind
//   it, and req_ready falls once all three stages are full; nothing is lost.
`default_nettype none

module thrust_allocation_mixer_top #(
   parameter int COEF_FRAC_BITS = tam_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tam_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tam_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tam_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tam_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tam_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import tam_pkg::*;

   localparam int PROD_W = DATA_W + COEF_FRAC_BITS + 3;

   limits_type               limits;
   logic                     clamp_valid;
   logic                     clamp_ready;
   logic signed [DATA_W-1:0] axis [NUM_AXES];
   logic                     mult_valid;
   logic                     mult_ready;
   logic signed [PROD_W-1:0] prod [NUM_PROPS][NUM_AXES];

   // limit registers
   tam_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limits      (limits)
   );

   // clamp and register inputs
   tam_clamp_stage u_clamp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .limits    (limits),
      .out_valid (clamp_valid),
      .out_ready (clamp_ready),
      .axis_out  (axis)
   );

   // products
   tam_mult_stage #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (clamp_valid),
      .in_ready  (clamp_ready),
      .axis_in   (axis),
      .out_valid (mult_valid),
      .out_ready (mult_ready),
      .prod_out  (prod)
   );

   // sums and result register
   tam_sum_stage #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mult_valid),
      .in_ready  (mult_ready),
      .prod_in   (prod),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/tam_csr.sv
// Configuration registers of the thrust allocation mixer: force and torque
// limits behind an APB-style port. Depends on tam_pkg.
`default_nettype none

module tam_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tam_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tam_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tam_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output tam_pkg::limits_type            limits
);
   import tam_pkg::*;

   limits_type    limits_ff;
   limits_type    limits_in;
   logic          wr_en;
   reg_index_type reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register write decode
   always_comb begin
      limits_in = limits_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_FORCE_LIMIT:  limits_in.force_limit  = csr_pwdata[LIMIT_W-1:0];
            REG_TORQUE_LIMIT: limits_in.torque_limit = csr_pwdata[LIMIT_W-1:0];
            default:          limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.force_limit  <= LIMIT_RESET;
         limits_ff.torque_limit <= LIMIT_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_FORCE_LIMIT:
            csr_prdata = CSR_DATA_W'(limits_ff.force_limit);
         REG_TORQUE_LIMIT:
            csr_prdata = CSR_DATA_W'(limits_ff.torque_limit);
         default:
            csr_prdata = '0;
      endcase
   end

   assign limits = limits_ff;

endmodule

`default_nettype wire

### rtl/tam_clamp_stage.sv
// Input stage: clamps each force/torque component to its limit and
// registers the six clamped axes. Depends on tam_pkg.
`default_nettype none

module tam_clamp_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  tam_pkg::req_type                    in_data,
   input  tam_pkg::limits_type                 limits,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [tam_pkg::DATA_W-1:0]   axis_out [tam_pkg::NUM_AXES]
);
   import tam_pkg::*;

   logic                     valid_ff;
   logic                     valid_in;
   logic signed [DATA_W-1:0] axis_ff  [NUM_AXES];
   logic signed [DATA_W-1:0] axis_in  [NUM_AXES];
   logic signed [DATA_W-1:0] raw      [NUM_AXES];
   logic signed [DATA_W:0]   lim_pos  [NUM_AXES];
   logic signed [DATA_W:0]   lim_neg  [NUM_AXES];
   logic signed [DATA_W:0]   raw_ext  [NUM_AXES];

   assign raw[0] = in_data.force_x;
   assign raw[1] = in_data.force_y;
   assign raw[2] = in_data.force_z;
   assign raw[3] = in_data.torque_x;
   assign raw[4] = in_data.torque_y;
   assign raw[5] = in_data.torque_z;

   // clamp to [-limit, +limit]
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         lim_pos[a] = (a < NUM_FORCE_AXES) ?
                      $signed({2'b00, limits.force_limit}) :
                      $signed({2'b00, limits.torque_limit});
         lim_neg[a] = -lim_pos[a];
         raw_ext[a] = (DATA_W + 1)'(raw[a]);
         if (raw_ext[a] > lim_pos[a]) begin
            axis_in[a] = DATA_W'(lim_pos[a]);
         end else if (raw_ext[a] < lim_neg[a]) begin
            axis_in[a] = DATA_W'(lim_neg[a]);
         end else begin
            axis_in[a] = raw[a];
         end
      end
   end

   // stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         axis_ff <= axis_in;
      end
   end

   assign out_valid = valid_ff;
   assign axis_out  = axis_ff;

   // an offered force_x or torque_x never exceeds its upper limit
   assert property (@(posedge clock) disable iff (reset)
      in_valid |-> (axis_in[0] <= $signed({1'b0, limits.force_limit})) &&
                   (axis_in[3] <= $signed({1'b0, limits.torque_limit})))
      else $error("clamped axis above limit");

   // a stalled full stage stays full
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> valid_ff)
      else $error("clamp stage dropped a request");

endmodule

`default_nettype wire

### rtl/tam_mult_stage.sv
// Product stage: multiplies each clamped axis by the constant allocation
// coefficients and registers the 8x6 products. Depends on tam_pkg.
`default_nettype none

module tam_mult_stage #(
   parameter int COEF_FRAC_BITS = tam_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [tam_pkg::DATA_W-1:0]   axis_in [tam_pkg::NUM_AXES],
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [tam_pkg::DATA_W+COEF_FRAC_BITS+2:0]
                                               prod_out [tam_pkg::NUM_PROPS][tam_pkg::NUM_AXES]
);
   import tam_pkg::*;

   localparam int COEF_W = COEF_FRAC_BITS + 3;
   localparam int PROD_W = DATA_W + COEF_W;

   logic                     valid_ff;
   logic                     valid_in;
   logic signed [PROD_W-1:0] prod_ff [NUM_PROPS][NUM_AXES];
   logic signed [PROD_W-1:0] prod_in [NUM_PROPS][NUM_AXES];

   // constant-coefficient products
   for (genvar p = 0; p < NUM_PROPS; p++) begin : g_prop
      for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
         localparam logic signed [COEF_W-1:0] COEF =
            COEF_W'(signed_coef(p, a, COEF_FRAC_BITS));
         assign prod_in[p][a] = axis_in[a] * COEF;
      end
   end

   // stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod_out  = prod_ff;

endmodule

`default_nettype wire

### rtl/tam_sum_stage.sv
// Output stage: sums the six products per propeller, rounds to Q8.8,
// saturates and holds the result for the receiver. Depends on tam_pkg.
`default_nettype none

module tam_sum_stage #(
   parameter int COEF_FRAC_BITS = tam_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [tam_pkg::DATA_W+COEF_FRAC_BITS+2:0]
                                               prod_in [tam_pkg::NUM_PROPS][tam_pkg::NUM_AXES],
   output logic                                out_valid,
   input  logic                                out_ready,
   output tam_pkg::rsp_type                    out_data
);
   import tam_pkg::*;

   localparam int COEF_W = COEF_FRAC_BITS + 3;
   localparam int PROD_W = DATA_W + COEF_W;
   localparam int ACC_W  = PROD_W + 3;
   localparam int SH_W   = ACC_W - COEF_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [SH_W-1:0]  SAT_MAX    = SH_W'(DATA_MAX);
   localparam logic signed [SH_W-1:0]  SAT_MIN    = SH_W'(DATA_MIN);

   logic                     valid_ff;
   logic                     valid_in;
   logic signed [ACC_W-1:0]  acc     [NUM_PROPS];
   logic signed [ACC_W-1:0]  rnd     [NUM_PROPS];
   logic signed [SH_W-1:0]   shifted [NUM_PROPS];
   logic signed [DATA_W-1:0] thrust_in [NUM_PROPS];
   logic signed [DATA_W-1:0] thrust_ff [NUM_PROPS];

   // sum, round half up, saturate
   always_comb begin
      for (int p = 0; p < NUM_PROPS; p++) begin
         acc[p] = '0;
         for (int a = 0; a < NUM_AXES; a++) begin
            acc[p] = acc[p] + ACC_W'(prod_in[p][a]);
         end
         rnd[p]     = acc[p] + ROUND_HALF;
         shifted[p] = SH_W'(rnd[p] >>> COEF_FRAC_BITS);
         if (shifted[p] > SAT_MAX) begin
            thrust_in[p] = DATA_W'(SAT_MAX);
         end else if (shifted[p] < SAT_MIN) begin
            thrust_in[p] = DATA_W'(SAT_MIN);
         end else begin
            thrust_in[p] = DATA_W'(shifted[p]);
         end
      end
   end

   // result register handshake
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         thrust_ff <= thrust_in;
      end
   end

   assign out_valid         = valid_ff;
   assign out_data.thrust_0 = thrust_ff[0];
   assign out_data.thrust_1 = thrust_ff[1];
   assign out_data.thrust_2 = thrust_ff[2];
   assign out_data.thrust_3 = thrust_ff[3];
   assign out_data.thrust_4 = thrust_ff[4];
   assign out_data.thrust_5 = thrust_ff[5];
   assign out_data.thrust_6 = thrust_ff[6];
   assign out_data.thrust_7 = thrust_ff[7];

   // result register is empty right after reset
   assert property (@(posedge clock) reset |=> !valid_ff)
      else $error("result valid after reset");

   // a held result stays valid and keeps thrust_0 until taken
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> valid_ff && $stable(thrust_ff[0]))
      else $error("held result changed");

endmodule

`default_nettype wire
